### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the scalar multiplier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ECSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that must hold on every edge, reset included
`define ECSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared constants, status codes and modular helpers of the scalar multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecsm_pkg;

  localparam int DEF_WORD_BITS   = 32;
  localparam int DEF_SCALAR_BITS = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_BITS    = 2;
  localparam int STATUS_BITS     = 2;
  localparam int HW_BITS         = 64;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_A = 2'd1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_AFFINE = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_INF    = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FAIL   = 2'd2;

  // handshake of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // (x + y) mod m for x, y below m
  function automatic logic [HW_BITS-1:0] madd(input logic [HW_BITS-1:0] x,
                                              input logic [HW_BITS-1:0] y,
                                              input logic [HW_BITS-1:0] m);
    logic [HW_BITS-1:0] gap;
    gap  = m - y;
    madd = (x >= gap) ? (x - gap) : (x + y);
  endfunction

  // (x - y) mod m for x, y below m
  function automatic logic [HW_BITS-1:0] msub(input logic [HW_BITS-1:0] x,
                                              input logic [HW_BITS-1:0] y,
                                              input logic [HW_BITS-1:0] m);
    msub = (x >= y) ? (x - y) : (x + (m - y));
  endfunction

endpackage

`default_nettype wire

### hdl/ec_scalar_mult_mod_n.sv
// ----------------------------------------------------------------------------
// ec_scalar_mult_mod_n
// Affine elliptic-curve scalar multiplication modulo a configured modulus.
// ----------------------------------------------------------------------------
// Pulse start with a scalar and a point while busy is low; the item goes into
// a two-entry queue, so up to two items can wait behind the one in work. Each
// item produces exactly one result, shown for a single cycle with out_valid;
// the receiver cannot stall it, so capture it on that cycle. Status 2 means a
// denominator had no inverse, and that denominator is on out_bad_denominator.
// Datapath: the work runs on one bit-serial modular multiplier and one
// restoring divider for the Euclid quotients. A point operation costs up to
// five products plus one inversion of up to about 1.45*WORD_BITS Euclid
// steps, each one division and one product, and an item runs up to
// 2*SCALAR_BITS-1 point operations. A zero scalar or a point at infinity
// skips the arithmetic: the engine goes from idle straight to its finish
// state, which registers the result.
// Configuration writes take effect for items the engine picks up after them,
// queued ones included, so write only while nothing is in flight.
`timescale 1ns / 1ps
`default_nettype none

module ec_scalar_mult_mod_n import ecsm_pkg::*; #(
  parameter int WORD_BITS   = DEF_WORD_BITS,
  parameter int SCALAR_BITS = DEF_SCALAR_BITS
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire  [CFG_IDX_BITS-1:0] cfg_index,
  input  wire  [WORD_BITS-1:0]    cfg_wdata,
  input  wire                     start,
  output logic                    busy,
  input  wire  [SCALAR_BITS-1:0]  in_scalar,
  input  wire  [WORD_BITS-1:0]    in_point_x,
  input  wire  [WORD_BITS-1:0]    in_point_y,
  input  wire                     in_point_at_infinity,
  output logic                    out_valid,
  output logic [WORD_BITS-1:0]    out_result_x,
  output logic [WORD_BITS-1:0]    out_result_y,
  output logic [STATUS_BITS-1:0]  out_status,
  output logic [WORD_BITS-1:0]    out_bad_denominator
);

  logic [WORD_BITS-1:0]   modulus_r, curve_a_r;
  logic                   q_valid, q_pop, q_trivial;
  logic [SCALAR_BITS-1:0] q_scalar;
  logic [WORD_BITS-1:0]   q_x, q_y;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= WORD_BITS'(3);
      curve_a_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODULUS) begin
        modulus_r <= cfg_wdata;
      end else if (cfg_index == CFG_CURVE_A) begin
        curve_a_r <= cfg_wdata;
      end
    end
  end

  ecsm_front #(.WORD_BITS(WORD_BITS), .SCALAR_BITS(SCALAR_BITS)) u_front (
    .clk (clk), .rst_n (rst_n), .start (start), .busy (busy),
    .in_scalar (in_scalar), .in_point_x (in_point_x), .in_point_y (in_point_y),
    .in_point_at_infinity (in_point_at_infinity),
    .q_valid (q_valid), .q_pop (q_pop), .q_scalar (q_scalar),
    .q_x (q_x), .q_y (q_y), .q_trivial (q_trivial)
  );

  ecsm_back #(.WORD_BITS(WORD_BITS), .SCALAR_BITS(SCALAR_BITS)) u_back (
    .clk (clk), .rst_n (rst_n), .modulus (modulus_r), .curve_a (curve_a_r),
    .q_valid (q_valid), .q_pop (q_pop), .q_scalar (q_scalar),
    .q_x (q_x), .q_y (q_y), .q_trivial (q_trivial),
    .res_valid (out_valid), .res_x (out_result_x), .res_y (out_result_y),
    .res_status (out_status), .res_bad (out_bad_denominator)
  );

endmodule

`default_nettype wire

### hdl/ecsm_front.sv
// ----------------------------------------------------------------------------
// ecsm_front
// Accepts items, marks the trivial ones and queues them for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecsm_front import ecsm_pkg::*; #(
  parameter int WORD_BITS   = DEF_WORD_BITS,
  parameter int SCALAR_BITS = DEF_SCALAR_BITS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire  [SCALAR_BITS-1:0] in_scalar,
  input  wire  [WORD_BITS-1:0]   in_point_x,
  input  wire  [WORD_BITS-1:0]   in_point_y,
  input  wire                    in_point_at_infinity,
  output logic                   q_valid,
  input  wire                    q_pop,
  output logic [SCALAR_BITS-1:0] q_scalar,
  output logic [WORD_BITS-1:0]   q_x,
  output logic [WORD_BITS-1:0]   q_y,
  output logic                   q_trivial
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [SCALAR_BITS-1:0] sc_mem [QUEUE_DEPTH];
  logic [WORD_BITS-1:0]   x_mem  [QUEUE_DEPTH];
  logic [WORD_BITS-1:0]   y_mem  [QUEUE_DEPTH];
  logic                   tr_mem [QUEUE_DEPTH];

  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          accept;
  logic          pop;

  assign busy    = (cnt_r == CW'(QUEUE_DEPTH));
  assign accept  = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop && q_valid;

  // hand the head item to the engine
  assign q_scalar  = sc_mem[rd_ptr_r];
  assign q_x       = x_mem[rd_ptr_r];
  assign q_y       = y_mem[rd_ptr_r];
  assign q_trivial = tr_mem[rd_ptr_r];

  // store item; zero scalar or point at infinity needs no arithmetic
  always_ff @(posedge clk) begin
    if (accept) begin
      sc_mem[wr_ptr_r] <= in_scalar;
      x_mem[wr_ptr_r]  <= in_point_x;
      y_mem[wr_ptr_r]  <= in_point_y;
      tr_mem[wr_ptr_r] <= in_point_at_infinity || (in_scalar == '0);
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (accept && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !accept) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ecsm_mmul.sv
// ----------------------------------------------------------------------------
// ecsm_mmul
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecsm_mmul import ecsm_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  go,
  input  wire  [WORD_BITS-1:0] op_x,
  input  wire  [WORD_BITS-1:0] op_y,
  input  wire  [WORD_BITS-1:0] op_m,
  output logic [WORD_BITS-1:0] prod,
  output unit_stat_t           stat
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] acc_r, x_r, y_r, m_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;
  logic [WORD_BITS-1:0] dbl, acc_nxt;

  // double, then add x when the multiplier bit is set
  always_comb begin
    dbl     = WORD_BITS'(madd(HW_BITS'(acc_r), HW_BITS'(acc_r), HW_BITS'(m_r)));
    acc_nxt = y_r[WORD_BITS-1] ?
              WORD_BITS'(madd(HW_BITS'(dbl), HW_BITS'(x_r), HW_BITS'(m_r))) : dbl;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc_r <= '0;
      x_r   <= op_x;
      y_r   <= op_y;
      m_r   <= op_m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= y_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WORD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

### hdl/ecsm_div.sv
// ----------------------------------------------------------------------------
// ecsm_div
// Restoring divider, one quotient bit per cycle, for the Euclid steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecsm_div import ecsm_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  go,
  input  wire  [WORD_BITS-1:0] dividend,
  input  wire  [WORD_BITS-1:0] divisor,
  output logic [WORD_BITS-1:0] quo,
  output logic [WORD_BITS-1:0] rem,
  output unit_stat_t           stat
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] q_r, rem_r, d_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;
  logic [WORD_BITS:0]   trial;
  logic                 fits;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_r, q_r[WORD_BITS-1]};
    fits  = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? WORD_BITS'(trial - {1'b0, d_r}) : WORD_BITS'(trial);
      q_r   <= {q_r[WORD_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WORD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = q_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

### hdl/ecsm_back.sv
// ----------------------------------------------------------------------------
// ecsm_back
// Sequencer that runs double-and-add on the shared multiplier and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ecsm_back import ecsm_pkg::*; #(
  parameter int WORD_BITS   = DEF_WORD_BITS,
  parameter int SCALAR_BITS = DEF_SCALAR_BITS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  [WORD_BITS-1:0]   modulus,
  input  wire  [WORD_BITS-1:0]   curve_a,
  input  wire                    q_valid,
  output logic                   q_pop,
  input  wire  [SCALAR_BITS-1:0] q_scalar,
  input  wire  [WORD_BITS-1:0]   q_x,
  input  wire  [WORD_BITS-1:0]   q_y,
  input  wire                    q_trivial,
  output logic                   res_valid,
  output logic [WORD_BITS-1:0]   res_x,
  output logic [WORD_BITS-1:0]   res_y,
  output logic [STATUS_BITS-1:0] res_status,
  output logic [WORD_BITS-1:0]   res_bad
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_RA    = 21'h000002,
    S_RX    = 21'h000004,
    S_RY    = 21'h000008,
    S_LOOP  = 21'h000010,
    S_SHIFT = 21'h000020,
    S_ADD   = 21'h000040,
    S_D1    = 21'h000080,
    S_D2    = 21'h000100,
    S_INV0  = 21'h000200,
    S_IL    = 21'h000400,
    S_IQ    = 21'h000800,
    S_IT    = 21'h001000,
    S_C1    = 21'h002000,
    S_C2    = 21'h004000,
    S_C3    = 21'h008000,
    S_C4    = 21'h010000,
    S_WB    = 21'h020000,
    S_FIN   = 21'h040000,
    S_MULW  = 21'h080000,
    S_DIVW  = 21'h100000
  } state_t;

  state_t state_r, ret_r;

  logic [WORD_BITS-1:0]   m_r, a_r, xraw_r, yraw_r;
  logic [SCALAR_BITS-1:0] k_r;
  logic [WORD_BITS-1:0]   px_r, py_r, rx_r, ry_r;
  logic                   pinf_r, rinf_r;
  logic [WORD_BITS-1:0]   x1_r, y1_r, x2_r, y2_r;
  logic                   i1_r, i2_r, dst_acc_r;
  logic [WORD_BITS-1:0]   num_r, den_r, r0_r, r1_r, t0_r, t1_r;
  logic [WORD_BITS-1:0]   s_r, x3_r, ox_r, oy_r, mres_r, bad_r;
  logic                   oi_r, fail_r;
  logic [WORD_BITS-1:0]   mx_r, my_r, dd_r, dv_r;
  logic                   mul_go_r, div_go_r;
  logic                   res_valid_r;
  logic [WORD_BITS-1:0]   res_x_r, res_y_r, res_bad_r;
  logic [STATUS_BITS-1:0] res_status_r;

  logic [WORD_BITS-1:0]   mul_prod, div_quo, div_rem;
  unit_stat_t             mul_stat, div_stat;

  logic [WORD_BITS-1:0]   m_new, one, three, qm;
  logic [SCALAR_BITS-1:0] k_half;

  ecsm_mmul #(.WORD_BITS(WORD_BITS)) u_mmul (
    .clk (clk), .rst_n (rst_n), .go (mul_go_r),
    .op_x (mx_r), .op_y (my_r), .op_m (m_r),
    .prod (mul_prod), .stat (mul_stat)
  );

  ecsm_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk (clk), .rst_n (rst_n), .go (div_go_r),
    .dividend (dd_r), .divisor (dv_r),
    .quo (div_quo), .rem (div_rem), .stat (div_stat)
  );

  function automatic logic [WORD_BITS-1:0] fadd(input logic [WORD_BITS-1:0] x,
                                               input logic [WORD_BITS-1:0] y,
                                               input logic [WORD_BITS-1:0] m);
    fadd = WORD_BITS'(madd(HW_BITS'(x), HW_BITS'(y), HW_BITS'(m)));
  endfunction

  function automatic logic [WORD_BITS-1:0] fsub(input logic [WORD_BITS-1:0] x,
                                               input logic [WORD_BITS-1:0] y,
                                               input logic [WORD_BITS-1:0] m);
    fsub = WORD_BITS'(msub(HW_BITS'(x), HW_BITS'(y), HW_BITS'(m)));
  endfunction

  // small residues of the working modulus, the quotient reduced below it and the halved scalar
  always_comb begin
    m_new  = (modulus == '0) ? WORD_BITS'(1) : modulus;
    one    = (m_r == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
    if (m_r == WORD_BITS'(1) || m_r == WORD_BITS'(3)) begin
      three = '0;
    end else if (m_r == WORD_BITS'(2)) begin
      three = WORD_BITS'(1);
    end else begin
      three = WORD_BITS'(3);
    end
    qm     = (div_quo >= m_r) ? (div_quo - m_r) : div_quo;
    k_half = k_r >> 1;
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            m_r    <= m_new;
            k_r    <= q_scalar;
            xraw_r <= q_x;
            yraw_r <= q_y;
            rinf_r <= 1'b1;
            rx_r   <= '0;
            ry_r   <= '0;
            pinf_r <= 1'b0;
            fail_r <= 1'b0;
            if (q_trivial) begin
              state_r <= S_FIN;
            end else begin
              mx_r     <= (m_new == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
              my_r     <= curve_a;
              mul_go_r <= 1'b1;
              ret_r    <= S_RA;
              state_r  <= S_MULW;
            end
          end
        end
        S_MULW: begin
          if (mul_stat.done) begin
            mres_r  <= mul_prod;
            state_r <= ret_r;
          end
        end
        S_DIVW: begin
          if (div_stat.done) begin
            state_r <= S_IQ;
          end
        end
        S_RA: begin
          a_r      <= mres_r;
          mx_r     <= one;
          my_r     <= xraw_r;
          mul_go_r <= 1'b1;
          ret_r    <= S_RX;
          state_r  <= S_MULW;
        end
        S_RX: begin
          px_r     <= mres_r;
          mx_r     <= one;
          my_r     <= yraw_r;
          mul_go_r <= 1'b1;
          ret_r    <= S_RY;
          state_r  <= S_MULW;
        end
        S_RY: begin
          py_r    <= mres_r;
          state_r <= S_LOOP;
        end
        // add the running power into the accumulator on a set bit, else go on to the shift; finish when no bits remain
        S_LOOP: begin
          if (k_r == '0) begin
            state_r <= S_FIN;
          end else if (k_r[0]) begin
            x1_r <= px_r; y1_r <= py_r; i1_r <= pinf_r;
            x2_r <= rx_r; y2_r <= ry_r; i2_r <= rinf_r;
            dst_acc_r <= 1'b1;
            state_r   <= S_ADD;
          end else begin
            state_r <= S_SHIFT;
          end
        end
        // drop the used bit, double while bits remain
        S_SHIFT: begin
          k_r <= k_half;
          if (k_half == '0) begin
            state_r <= S_FIN;
          end else begin
            x1_r <= px_r; y1_r <= py_r; i1_r <= pinf_r;
            x2_r <= px_r; y2_r <= py_r; i2_r <= pinf_r;
            dst_acc_r <= 1'b0;
            state_r   <= S_ADD;
          end
        end
        S_ADD: begin
          if (i1_r) begin
            ox_r <= x2_r; oy_r <= y2_r; oi_r <= i2_r;
            state_r <= S_WB;
          end else if (i2_r) begin
            ox_r <= x1_r; oy_r <= y1_r; oi_r <= 1'b0;
            state_r <= S_WB;
          end else if (x1_r == x2_r) begin
            if (fadd(y1_r, y2_r, m_r) == '0) begin
              ox_r <= '0; oy_r <= '0; oi_r <= 1'b1;
              state_r <= S_WB;
            end else begin
              den_r    <= fadd(y1_r, y1_r, m_r);
              mx_r     <= x1_r;
              my_r     <= x1_r;
              mul_go_r <= 1'b1;
              ret_r    <= S_D1;
              state_r  <= S_MULW;
            end
          end else begin
            num_r   <= fsub(y2_r, y1_r, m_r);
            den_r   <= fsub(x2_r, x1_r, m_r);
            state_r <= S_INV0;
          end
        end
        S_D1: begin
          mx_r     <= three;
          my_r     <= mres_r;
          mul_go_r <= 1'b1;
          ret_r    <= S_D2;
          state_r  <= S_MULW;
        end
        S_D2: begin
          num_r   <= fadd(mres_r, a_r, m_r);
          state_r <= S_INV0;
        end
        S_INV0: begin
          r0_r    <= m_r;
          r1_r    <= den_r;
          t0_r    <= '0;
          t1_r    <= one;
          state_r <= S_IL;
        end
        // one Euclid step per pass
        S_IL: begin
          if (r1_r == '0) begin
            if (r0_r == WORD_BITS'(1)) begin
              mx_r     <= num_r;
              my_r     <= t0_r;
              mul_go_r <= 1'b1;
              ret_r    <= S_C1;
              state_r  <= S_MULW;
            end else begin
              fail_r  <= 1'b1;
              bad_r   <= den_r;
              state_r <= S_FIN;
            end
          end else begin
            dd_r     <= r0_r;
            dv_r     <= r1_r;
            div_go_r <= 1'b1;
            state_r  <= S_DIVW;
          end
        end
        S_IQ: begin
          r0_r     <= r1_r;
          r1_r     <= div_rem;
          mx_r     <= qm;
          my_r     <= t1_r;
          mul_go_r <= 1'b1;
          ret_r    <= S_IT;
          state_r  <= S_MULW;
        end
        S_IT: begin
          t1_r    <= fsub(t0_r, mres_r, m_r);
          t0_r    <= t1_r;
          state_r <= S_IL;
        end
        S_C1: begin
          s_r      <= mres_r;
          mx_r     <= mres_r;
          my_r     <= mres_r;
          mul_go_r <= 1'b1;
          ret_r    <= S_C2;
          state_r  <= S_MULW;
        end
        S_C2: begin
          x3_r    <= fsub(fsub(mres_r, x1_r, m_r), x2_r, m_r);
          state_r <= S_C3;
        end
        S_C3: begin
          mx_r     <= s_r;
          my_r     <= fsub(x1_r, x3_r, m_r);
          mul_go_r <= 1'b1;
          ret_r    <= S_C4;
          state_r  <= S_MULW;
        end
        S_C4: begin
          ox_r    <= x3_r;
          oy_r    <= fsub(mres_r, y1_r, m_r);
          oi_r    <= 1'b0;
          state_r <= S_WB;
        end
        S_WB: begin
          if (dst_acc_r) begin
            rx_r <= ox_r; ry_r <= oy_r; rinf_r <= oi_r;
            state_r <= S_SHIFT;
          end else begin
            px_r <= ox_r; py_r <= oy_r; pinf_r <= oi_r;
            state_r <= S_LOOP;
          end
        end
        S_FIN: begin
          res_valid_r <= 1'b1;
          if (fail_r) begin
            res_x_r <= '0; res_y_r <= '0; res_status_r <= ST_FAIL; res_bad_r <= bad_r;
          end else if (rinf_r) begin
            res_x_r <= '0; res_y_r <= '0; res_status_r <= ST_INF; res_bad_r <= '0;
          end else begin
            res_x_r <= rx_r; res_y_r <= ry_r; res_status_r <= ST_AFFINE; res_bad_r <= '0;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid  = res_valid_r;
  assign res_x      = res_x_r;
  assign res_y      = res_y_r;
  assign res_status = res_status_r;
  assign res_bad    = res_bad_r;

  `ECSM_ASSERT(a_res_single, res_valid_r |=> !res_valid_r, "result strobe longer than one cycle")
  `ECSM_ASSERT(a_fail_zero, (res_valid_r && res_status_r == ST_FAIL) |-> (res_x_r == '0 && res_y_r == '0), "failed result carries a point")
  `ECSM_ASSERT(a_mul_free, mul_go_r |-> !mul_stat.busy, "multiplier started while busy")
  `ECSM_ASSERT(a_units_excl, !(mul_stat.busy && div_stat.busy), "multiplier and divider run together")

endmodule

`default_nettype wire
